[rtl/ffa_pkg.sv]
// ----------------------------------------------------------------------------
// ffa_pkg
// Types, codes and helpers shared by the first-fit free-list allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ffa_pkg;

    localparam int UNIT_W = 24;
    localparam logic [UNIT_W-1:0] UNIT_MAX = {UNIT_W{1'b1}};
    localparam logic [UNIT_W-1:0] POOL_RESET = 24'd200000;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_NO_FIT = 2'd1;
    localparam logic [1:0] STATUS_FULL   = 2'd2;

    typedef struct packed {
        logic [UNIT_W-1:0] start;
        logic [UNIT_W-1:0] length;
    } extent_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [UNIT_W-1:0] alloc_offset;
    } res_t;

    localparam int EXTENT_W = $bits(extent_t);
    localparam int RES_W    = $bits(res_t);

    function automatic logic [UNIT_W-1:0] sat_add(input logic [UNIT_W-1:0] a,
                                                  input logic [UNIT_W-1:0] b);
        logic [UNIT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[UNIT_W] ? UNIT_MAX : s[UNIT_W-1:0];
    endfunction

endpackage

[rtl/ffa_ram.sv]
// ----------------------------------------------------------------------------
// ffa_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffa_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/ffa_out_reg.sv]
// ----------------------------------------------------------------------------
// ffa_out_reg
// One-entry output register between the sequencer and the result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffa_out_reg #(
    parameter int WIDTH = 33
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic             valid_reg;
    logic             valid_next;
    logic [WIDTH-1:0] data_reg;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg;
        if (out_ready) begin
            valid_next = 1'b0;
        end
        if (in_valid && in_ready) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= in_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[rtl/ffa_seq.sv]
// ----------------------------------------------------------------------------
// ffa_seq
// Table sequencer: first-fit scan, trim or removal in the live bank; on free,
// copy to scratch bank, insert, sort, coalesce, commit by bank swap if room.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffa_seq
    import ffa_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [UNIT_W-1:0]              cfg_wr_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           in_command,
    input  logic [UNIT_W-1:0]              in_length,
    input  logic [UNIT_W-1:0]              in_offset,
    output logic                           res_valid,
    input  logic                           res_ready,
    output res_t                           res_info,
    output logic [$clog2(DEPTH+1)-1:0]     res_count
);

    localparam int AW      = $clog2(DEPTH + 1);
    localparam int NW      = $clog2(DEPTH + 2);
    localparam int RAW     = AW + 1;
    localparam int RAM_DEP = 2 ** RAW;

    localparam logic [3:0] ST_INIT     = 4'd0;
    localparam logic [3:0] ST_IDLE     = 4'd1;
    localparam logic [3:0] ST_A_START  = 4'd2;
    localparam logic [3:0] ST_A_SCAN   = 4'd3;
    localparam logic [3:0] ST_A_SHIFT  = 4'd4;
    localparam logic [3:0] ST_F_COPY   = 4'd5;
    localparam logic [3:0] ST_F_NEW    = 4'd6;
    localparam logic [3:0] ST_S_RDKEY  = 4'd7;
    localparam logic [3:0] ST_S_GETKEY = 4'd8;
    localparam logic [3:0] ST_S_CMP    = 4'd9;
    localparam logic [3:0] ST_S_PUT    = 4'd10;
    localparam logic [3:0] ST_M_RD0    = 4'd11;
    localparam logic [3:0] ST_M_LD0    = 4'd12;
    localparam logic [3:0] ST_M_STEP   = 4'd13;
    localparam logic [3:0] ST_M_FLUSH  = 4'd14;
    localparam logic [3:0] ST_DONE     = 4'd15;

    logic [3:0]        state_reg,  state_next;
    logic              bank_reg,   bank_next;
    logic [AW-1:0]     count_reg,  count_next;
    logic [UNIT_W-1:0] pool_reg,   pool_next;
    logic [UNIT_W-1:0] len_reg,    len_next;
    logic [UNIT_W-1:0] off_reg,    off_next;
    logic [NW-1:0]     m_reg,      m_next;
    logic [AW-1:0]     i_reg,      i_next;
    logic [AW-1:0]     j_reg,      j_next;
    extent_t           key_reg,    key_next;
    extent_t           cur_reg,    cur_next;
    logic [1:0]        status_reg, status_next;
    logic [UNIT_W-1:0] aoff_reg,   aoff_next;

    logic              ram_we;
    logic [RAW-1:0]    ram_waddr;
    extent_t           ram_wdata;
    logic [RAW-1:0]    ram_raddr;
    logic [EXTENT_W-1:0] ram_rdata;
    extent_t           rd;

    logic              act;
    logic              scr;
    logic [AW-1:0]     ip1, im1, jp1, jp2, jm1, jm2;
    logic [NW-1:0]     ip1_w;
    logic [UNIT_W:0]   end_sum;
    logic              touch;

    ffa_ram #(
        .WIDTH (EXTENT_W),
        .DEPTH (RAM_DEP)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd      = ram_rdata;
    assign act     = bank_reg;
    assign scr     = ~bank_reg;
    assign ip1     = i_reg + AW'(1);
    assign im1     = i_reg - AW'(1);
    assign jp1     = j_reg + AW'(1);
    assign jp2     = j_reg + AW'(2);
    assign jm1     = j_reg - AW'(1);
    assign jm2     = j_reg - AW'(2);
    assign ip1_w   = NW'(i_reg) + NW'(1);
    assign end_sum = {1'b0, cur_reg.start} + {1'b0, cur_reg.length};
    assign touch   = end_sum == {1'b0, rd.start};

    always_comb begin
        state_next  = state_reg;
        bank_next   = bank_reg;
        count_next  = count_reg;
        pool_next   = pool_reg;
        len_next    = len_reg;
        off_next    = off_reg;
        m_next      = m_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        key_next    = key_reg;
        cur_next    = cur_reg;
        status_next = status_reg;
        aoff_next   = aoff_reg;
        ram_we      = 1'b0;
        ram_waddr   = {act, i_reg};
        ram_wdata   = rd;
        ram_raddr   = {act, i_reg};
        in_ready    = 1'b0;
        res_valid   = 1'b0;

        unique case (state_reg)
            ST_INIT: begin
                ram_we     = 1'b1;
                ram_waddr  = {act, AW'(0)};
                ram_wdata  = '{start: '0, length: pool_reg};
                count_next = AW'(1);
                state_next = ST_IDLE;
            end
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    len_next  = in_length;
                    off_next  = in_offset;
                    i_next    = '0;
                    aoff_next = '0;
                    if (in_command == CMD_FREE) begin
                        state_next = ST_F_COPY;
                    end else begin
                        state_next = ST_A_START;
                    end
                end
            end
            ST_A_START: begin
                if (count_reg == '0) begin
                    status_next = STATUS_NO_FIT;
                    state_next  = ST_DONE;
                end else begin
                    state_next = ST_A_SCAN;
                end
            end
            ST_A_SCAN: begin
                if (rd.length >= len_reg) begin
                    aoff_next   = rd.start;
                    status_next = STATUS_OK;
                    if (rd.length == len_reg) begin
                        j_next = i_reg;
                        if (ip1 < count_reg) begin
                            ram_raddr  = {act, ip1};
                            state_next = ST_A_SHIFT;
                        end else begin
                            count_next = count_reg - AW'(1);
                            state_next = ST_DONE;
                        end
                    end else begin
                        ram_we     = 1'b1;
                        ram_waddr  = {act, i_reg};
                        ram_wdata  = '{start:  sat_add(rd.start, len_reg),
                                       length: rd.length - len_reg};
                        state_next = ST_DONE;
                    end
                end else if (ip1 == count_reg) begin
                    status_next = STATUS_NO_FIT;
                    state_next  = ST_DONE;
                end else begin
                    i_next    = ip1;
                    ram_raddr = {act, ip1};
                end
            end
            ST_A_SHIFT: begin
                ram_we    = 1'b1;
                ram_waddr = {act, j_reg};
                ram_wdata = rd;
                j_next    = jp1;
                if (jp2 < count_reg) begin
                    ram_raddr = {act, jp2};
                end else begin
                    count_next = count_reg - AW'(1);
                    state_next = ST_DONE;
                end
            end
            ST_F_COPY: begin
                ram_raddr = {act, i_reg};
                if (i_reg != '0) begin
                    ram_we    = 1'b1;
                    ram_waddr = {scr, im1};
                    ram_wdata = rd;
                end
                if (i_reg == count_reg) begin
                    state_next = ST_F_NEW;
                end else begin
                    i_next = ip1;
                end
            end
            ST_F_NEW: begin
                ram_we    = 1'b1;
                ram_waddr = {scr, count_reg};
                ram_wdata = '{start: off_reg, length: len_reg};
                m_next    = NW'(count_reg) + NW'(1);
                if (count_reg == '0) begin
                    state_next = ST_M_RD0;
                end else begin
                    i_next     = AW'(1);
                    state_next = ST_S_RDKEY;
                end
            end
            ST_S_RDKEY: begin
                ram_raddr  = {scr, i_reg};
                state_next = ST_S_GETKEY;
            end
            ST_S_GETKEY: begin
                key_next   = rd;
                j_next     = i_reg;
                ram_raddr  = {scr, im1};
                state_next = ST_S_CMP;
            end
            ST_S_CMP: begin
                ram_we    = 1'b1;
                ram_waddr = {scr, j_reg};
                if (rd.start > key_reg.start) begin
                    ram_wdata = rd;
                    j_next    = jm1;
                    if (jm1 != '0) begin
                        ram_raddr = {scr, jm2};
                    end else begin
                        state_next = ST_S_PUT;
                    end
                end else begin
                    ram_wdata = key_reg;
                    i_next    = ip1;
                    if (ip1_w == m_reg) begin
                        state_next = ST_M_RD0;
                    end else begin
                        ram_raddr  = {scr, ip1};
                        state_next = ST_S_GETKEY;
                    end
                end
            end
            ST_S_PUT: begin
                ram_we    = 1'b1;
                ram_waddr = {scr, AW'(0)};
                ram_wdata = key_reg;
                i_next    = ip1;
                if (ip1_w == m_reg) begin
                    state_next = ST_M_RD0;
                end else begin
                    ram_raddr  = {scr, ip1};
                    state_next = ST_S_GETKEY;
                end
            end
            ST_M_RD0: begin
                ram_raddr  = {scr, AW'(0)};
                state_next = ST_M_LD0;
            end
            ST_M_LD0: begin
                cur_next = rd;
                i_next   = AW'(1);
                j_next   = '0;
                if (m_reg == NW'(1)) begin
                    state_next = ST_M_FLUSH;
                end else begin
                    ram_raddr  = {scr, AW'(1)};
                    state_next = ST_M_STEP;
                end
            end
            ST_M_STEP: begin
                if (touch) begin
                    cur_next.length = sat_add(cur_reg.length, rd.length);
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = {scr, j_reg};
                    ram_wdata = cur_reg;
                    j_next    = jp1;
                    cur_next  = rd;
                end
                if (ip1_w == m_reg) begin
                    state_next = ST_M_FLUSH;
                end else begin
                    i_next    = ip1;
                    ram_raddr = {scr, ip1};
                end
            end
            ST_M_FLUSH: begin
                ram_we    = 1'b1;
                ram_waddr = {scr, j_reg};
                ram_wdata = cur_reg;
                if (j_reg == AW'(DEPTH)) begin
                    status_next = STATUS_FULL;
                end else begin
                    status_next = STATUS_OK;
                    bank_next   = scr;
                    count_next  = jp1;
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase

        if (cfg_wr_en) begin
            pool_next  = cfg_wr_data;
            state_next = ST_INIT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
            bank_reg  <= 1'b0;
            count_reg <= '0;
            pool_reg  <= POOL_RESET;
        end else begin
            state_reg <= state_next;
            bank_reg  <= bank_next;
            count_reg <= count_next;
            pool_reg  <= pool_next;
        end
    end

    always_ff @(posedge aclk) begin
        len_reg    <= len_next;
        off_reg    <= off_next;
        m_reg      <= m_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        key_reg    <= key_next;
        cur_reg    <= cur_next;
        status_reg <= status_next;
        aoff_reg   <= aoff_next;
    end

    assign res_info  = '{status: status_reg, alloc_offset: aoff_reg};
    assign res_count = count_reg;

endmodule

[rtl/first_fit_free_list_allocator.sv]
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator
// First-fit allocator over an offset-sorted free-extent table; coalesce on free.
// Allocate scans the extents in order; free copies the table, inserts the new
// extent, sorts, coalesces and commits. The sequencer takes a new request only
// once the last result is handed on. Reset or a pool_size write reloads the
// table with one extent.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module first_fit_free_list_allocator
    import ffa_pkg::*;
#(
    parameter int FREE_TABLE_DEPTH = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [UNIT_W-1:0]                   cfg_wr_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_command,
    input  logic [UNIT_W-1:0]                   s_block_length,
    input  logic [UNIT_W-1:0]                   s_block_offset,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [1:0]                          m_status,
    output logic [UNIT_W-1:0]                   m_alloc_offset,
    output logic [$clog2(FREE_TABLE_DEPTH+1)-1:0] m_free_extents
);

    localparam int CW    = $clog2(FREE_TABLE_DEPTH + 1);
    localparam int OUT_W = RES_W + CW;

    logic             res_valid;
    logic             res_ready;
    res_t             res_info;
    logic [CW-1:0]    res_count;
    logic [OUT_W-1:0] out_data;

    ffa_seq #(
        .DEPTH (FREE_TABLE_DEPTH)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_command  (s_command),
        .in_length   (s_block_length),
        .in_offset   (s_block_offset),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_info    (res_info),
        .res_count   (res_count)
    );

    ffa_out_reg #(
        .WIDTH (OUT_W)
    ) u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_ready  (res_ready),
        .in_data   ({res_info, res_count}),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_data)
    );

    assign m_free_extents = out_data[CW-1:0];
    assign m_alloc_offset = out_data[CW +: UNIT_W];
    assign m_status       = out_data[OUT_W-1 -: 2];

endmodule

[test/first_fit_free_list_allocator_test.sv]
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator_test
// Self-checking bench for the first-fit free-list allocator. A directed table
// covers the reset state, the empty table, zero-length requests, equal starts,
// overlapping extents and saturation at the top of the unit range. Random
// allocate/free traffic over several pool sizes then fragments, overflows and
// re-coalesces the free table. Results are checked against typed rows or an
// in-bench extent-table model; both channels idle at random bar the last run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module first_fit_free_list_allocator_test;
    import ffa_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam int COUNT_W = $clog2(TABLE_DEPTH + 1);

    typedef struct packed {
        logic [1:0]         status;
        logic [UNIT_W-1:0]  offset;
        logic [COUNT_W-1:0] extents;
    } outcome_t;

    typedef enum logic {ROW_POOL, ROW_REQUEST} row_kind_e;

    typedef struct packed {
        row_kind_e         kind;
        logic              command;
        logic [UNIT_W-1:0] length;
        logic [UNIT_W-1:0] offset;
        logic              typed;
        outcome_t          want;
    } stim_row_t;

    logic               aclk;
    logic               aresetn = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [UNIT_W-1:0]  cfg_wr_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_command = CMD_ALLOC;
    logic [UNIT_W-1:0]  s_block_length = '0;
    logic [UNIT_W-1:0]  s_block_offset = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [1:0]         m_status;
    logic [UNIT_W-1:0]  m_alloc_offset;
    logic [COUNT_W-1:0] m_free_extents;

    logic [UNIT_W-1:0] free_start [TABLE_DEPTH];
    logic [UNIT_W-1:0] free_length [TABLE_DEPTH];
    int                free_count;

    outcome_t  pending_outcomes[$];
    extent_t   held_blocks[$];
    stim_row_t directed_rows[$];
    int        mismatch_count = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    int        recv_stall_left = 0;

    first_fit_free_list_allocator #(
        .FREE_TABLE_DEPTH(TABLE_DEPTH)
    ) u_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_command(s_command),
        .s_block_length(s_block_length),
        .s_block_offset(s_block_offset),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_status(m_status),
        .m_alloc_offset(m_alloc_offset),
        .m_free_extents(m_free_extents)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #50_000_000;
        $display("first_fit_free_list_allocator_test NOT OK");
        $finish;
    end

    function automatic logic [UNIT_W-1:0] rand_units(input int unsigned lo,
                                                     input int unsigned hi);
        logic [31:0] r;
        r = $urandom_range(hi, lo);
        return r[UNIT_W-1:0];
    endfunction

    function automatic logic [UNIT_W-1:0] sum_or_top(input logic [UNIT_W-1:0] a,
                                                     input logic [UNIT_W-1:0] b);
        logic [UNIT_W:0] wide;
        wide = {1'b0, a} + {1'b0, b};
        return (wide > {1'b0, UNIT_MAX}) ? UNIT_MAX : wide[UNIT_W-1:0];
    endfunction

    task automatic reload_table(input logic [UNIT_W-1:0] pool);
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            free_start[i] = '0;
            free_length[i] = '0;
        end
        free_length[0] = pool;
        free_count = 1;
    endtask

    task automatic alloc_first_fit(input logic [UNIT_W-1:0] want_len, output outcome_t res);
        bit found;
        found = 1'b0;
        res.status = STATUS_NO_FIT;
        res.offset = '0;
        for (int i = 0; i < free_count; i++) begin
            if (!found && free_length[i] >= want_len) begin
                found = 1'b1;
                res.status = STATUS_OK;
                res.offset = free_start[i];
                if (free_length[i] == want_len) begin
                    for (int k = i; k + 1 < free_count; k++) begin
                        free_start[k] = free_start[k + 1];
                        free_length[k] = free_length[k + 1];
                    end
                    free_count--;
                    free_start[free_count] = '0;
                    free_length[free_count] = '0;
                end else begin
                    free_start[i] = sum_or_top(free_start[i], want_len);
                    free_length[i] = free_length[i] - want_len;
                end
            end
        end
        res.extents = free_count[COUNT_W-1:0];
    endtask

    task automatic free_and_merge(input logic [UNIT_W-1:0] at, input logic [UNIT_W-1:0] len,
                                  output outcome_t res);
        logic [UNIT_W-1:0] run_start [TABLE_DEPTH + 1];
        logic [UNIT_W-1:0] run_length [TABLE_DEPTH + 1];
        logic [UNIT_W-1:0] key_start;
        logic [UNIT_W-1:0] key_length;
        int n;
        int i;
        int j;
        for (i = 0; i < free_count; i++) begin
            run_start[i] = free_start[i];
            run_length[i] = free_length[i];
        end
        run_start[free_count] = at;
        run_length[free_count] = len;
        n = free_count + 1;
        // stable insertion sort on start
        for (i = 1; i < n; i++) begin
            key_start = run_start[i];
            key_length = run_length[i];
            j = i;
            while (j > 0 && run_start[j - 1] > key_start) begin
                run_start[j] = run_start[j - 1];
                run_length[j] = run_length[j - 1];
                j--;
            end
            run_start[j] = key_start;
            run_length[j] = key_length;
        end
        // join neighbours that touch exactly
        i = 0;
        while (i + 1 < n) begin
            if ({1'b0, run_start[i]} + {1'b0, run_length[i]} == {1'b0, run_start[i + 1]}) begin
                run_length[i] = sum_or_top(run_length[i], run_length[i + 1]);
                for (j = i + 1; j + 1 < n; j++) begin
                    run_start[j] = run_start[j + 1];
                    run_length[j] = run_length[j + 1];
                end
                n--;
            end else begin
                i++;
            end
        end
        res.offset = '0;
        if (n > TABLE_DEPTH) begin
            res.status = STATUS_FULL;
        end else begin
            res.status = STATUS_OK;
            for (i = 0; i < TABLE_DEPTH; i++) begin
                free_start[i] = (i < n) ? run_start[i] : '0;
                free_length[i] = (i < n) ? run_length[i] : '0;
            end
            free_count = n;
        end
        res.extents = free_count[COUNT_W-1:0];
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= 200)
            $display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    always @(posedge aclk) begin
        if (recv_idle_pct != 0 && recv_stall_left > 0) begin
            recv_stall_left--;
            m_ready <= 1'b0;
        end else if (recv_idle_pct != 0 && $urandom_range(99, 0) < recv_idle_pct) begin
            recv_stall_left = $urandom_range(15, 0);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : check_results
        outcome_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_outcomes.size() == 0) begin
                report_mismatch("unexpected result", m_status, 0);
            end else begin
                want = pending_outcomes.pop_front();
                if (m_status !== want.status)
                    report_mismatch("status", m_status, want.status);
                if (m_alloc_offset !== want.offset)
                    report_mismatch("alloc_offset", m_alloc_offset, want.offset);
                if (m_free_extents !== want.extents)
                    report_mismatch("free_extents", m_free_extents, want.extents);
            end
        end
    end

    task automatic send_request(input logic cmd, input logic [UNIT_W-1:0] len,
                                input logic [UNIT_W-1:0] off, input logic use_typed,
                                input outcome_t typed, output outcome_t got);
        if (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(16, 1)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_command <= cmd;
        s_block_length <= len;
        s_block_offset <= off;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        if (cmd == CMD_ALLOC)
            alloc_first_fit(len, got);
        else
            free_and_merge(off, len, got);
        pending_outcomes.insert(pending_outcomes.size(), use_typed ? typed : got);
    endtask

    task automatic wait_until_drained();
        s_valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_pool(input logic [UNIT_W-1:0] pool);
        wait_until_drained();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= pool;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        reload_table(pool);
        held_blocks.delete();
    endtask

    task automatic request_alloc(input logic [UNIT_W-1:0] len);
        outcome_t got;
        extent_t blk;
        send_request(CMD_ALLOC, len, rand_units(0, 32'hFFFFFF), 1'b0, '0, got);
        if (got.status == STATUS_OK && len != 0) begin
            blk.start = got.offset;
            blk.length = len;
            held_blocks.insert(held_blocks.size(), blk);
        end
    endtask

    task automatic release_held(input int idx);
        outcome_t got;
        extent_t blk;
        blk = held_blocks[idx];
        send_request(CMD_FREE, blk.length, blk.start, 1'b0, '0, got);
        if (got.status == STATUS_OK)
            held_blocks.delete(idx);
    endtask

    task automatic release_stray(input logic [UNIT_W-1:0] off, input logic [UNIT_W-1:0] len);
        outcome_t got;
        send_request(CMD_FREE, len, off, 1'b0, '0, got);
    endtask

    task automatic shuffle_idling();
        send_idle_pct = 15 * $urandom_range(2, 0);
        recv_idle_pct = 15 * $urandom_range(2, 0);
    endtask

    task automatic run_mixed(input int items, input int unsigned max_len,
                             input int unsigned span);
        int pick;
        for (int n = 0; n < items; n++) begin
            if (n % 60 == 59)
                wait_until_drained();
            pick = $urandom_range(99, 0);
            if (held_blocks.size() == 0 || pick < 45) begin
                if (pick < 3)
                    request_alloc('0);
                else if (pick < 6)
                    request_alloc(rand_units(span + 1, 32'hFFFFFF));
                else
                    request_alloc(rand_units(1, max_len));
            end else if (pick < 90) begin
                release_held($urandom_range(held_blocks.size() - 1, 0));
            end else begin
                release_stray(rand_units(0, span + max_len), rand_units(0, max_len));
            end
        end
    endtask

    function automatic stim_row_t check_row(input logic cmd, input logic [UNIT_W-1:0] len,
                                            input logic [UNIT_W-1:0] off,
                                            input logic [1:0] status,
                                            input logic [UNIT_W-1:0] aoff,
                                            input logic [COUNT_W-1:0] extents);
        stim_row_t row;
        row.kind = ROW_REQUEST;
        row.command = cmd;
        row.length = len;
        row.offset = off;
        row.typed = 1'b1;
        row.want.status = status;
        row.want.offset = aoff;
        row.want.extents = extents;
        return row;
    endfunction

    function automatic stim_row_t model_row(input logic cmd, input logic [UNIT_W-1:0] len,
                                            input logic [UNIT_W-1:0] off);
        stim_row_t row;
        row = check_row(cmd, len, off, STATUS_OK, '0, '0);
        row.typed = 1'b0;
        return row;
    endfunction

    function automatic stim_row_t pool_row(input logic [UNIT_W-1:0] pool);
        stim_row_t row;
        row = model_row(CMD_ALLOC, pool, '0);
        row.kind = ROW_POOL;
        return row;
    endfunction

    task automatic add_row(input stim_row_t row);
        directed_rows.insert(directed_rows.size(), row);
    endtask

    initial begin
        outcome_t  got;
        stim_row_t row;
        send_idle_pct = 20;
        recv_idle_pct = 20;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        reload_table(POOL_RESET);
        @(posedge aclk);

        // reset pool, empty table, zero lengths
        add_row(check_row(CMD_ALLOC, 24'd1, 24'd0, STATUS_OK, 24'd0, 7'd1));
        add_row(check_row(CMD_ALLOC, 24'd0, 24'hFFFFFF, STATUS_OK, 24'd1, 7'd1));
        add_row(check_row(CMD_ALLOC, 24'd199999, 24'd0, STATUS_OK, 24'd1, 7'd0));
        add_row(check_row(CMD_ALLOC, 24'd0, 24'd0, STATUS_NO_FIT, 24'd0, 7'd0));
        add_row(check_row(CMD_ALLOC, 24'hFFFFFF, 24'd0, STATUS_NO_FIT, 24'd0, 7'd0));
        add_row(check_row(CMD_FREE, 24'd0, 24'd0, STATUS_OK, 24'd0, 7'd1));
        add_row(check_row(CMD_ALLOC, 24'd0, 24'd0, STATUS_OK, 24'd0, 7'd0));
        // coalescing, overlaps and equal starts
        add_row(check_row(CMD_FREE, 24'd50, 24'd100, STATUS_OK, 24'd0, 7'd1));
        add_row(check_row(CMD_FREE, 24'd100, 24'd0, STATUS_OK, 24'd0, 7'd1));
        add_row(check_row(CMD_FREE, 24'd10, 24'd150, STATUS_OK, 24'd0, 7'd1));
        add_row(check_row(CMD_FREE, 24'd30, 24'd140, STATUS_OK, 24'd0, 7'd2));
        add_row(check_row(CMD_FREE, 24'd5, 24'd140, STATUS_OK, 24'd0, 7'd3));
        add_row(check_row(CMD_ALLOC, 24'hFFFFFF, 24'd0, STATUS_NO_FIT, 24'd0, 7'd3));
        add_row(check_row(CMD_ALLOC, 24'd160, 24'd0, STATUS_OK, 24'd0, 7'd2));
        // zero and one-unit pools
        add_row(pool_row(24'd0));
        add_row(check_row(CMD_ALLOC, 24'd1, 24'd0, STATUS_NO_FIT, 24'd0, 7'd1));
        add_row(check_row(CMD_ALLOC, 24'd0, 24'd0, STATUS_OK, 24'd0, 7'd0));
        add_row(pool_row(24'd1));
        add_row(check_row(CMD_ALLOC, 24'd2, 24'd0, STATUS_NO_FIT, 24'd0, 7'd1));
        add_row(check_row(CMD_ALLOC, 24'd1, 24'd0, STATUS_OK, 24'd0, 7'd0));
        // saturation at the top of the range
        add_row(pool_row(UNIT_MAX));
        add_row(check_row(CMD_FREE, UNIT_MAX, UNIT_MAX, STATUS_OK, 24'd0, 7'd1));
        add_row(check_row(CMD_ALLOC, UNIT_MAX, 24'd0, STATUS_OK, 24'd0, 7'd0));
        add_row(check_row(CMD_FREE, 24'h100, 24'hFFFFF0, STATUS_OK, 24'd0, 7'd1));
        add_row(check_row(CMD_ALLOC, 24'h20, 24'd0, STATUS_OK, 24'hFFFFF0, 7'd1));
        add_row(check_row(CMD_ALLOC, 24'h10, 24'd0, STATUS_OK, 24'hFFFFFF, 7'd1));
        add_row(model_row(CMD_FREE, 24'h555555, 24'hAAAAAA));
        add_row(model_row(CMD_ALLOC, 24'h555555, 24'h555555));

        for (int r = 0; r < directed_rows.size(); r++) begin
            row = directed_rows[r];
            if (row.kind == ROW_POOL)
                write_pool(row.length);
            else
                send_request(row.command, row.length, row.offset, row.typed, row.want, got);
        end

        // small pool, mixed traffic
        shuffle_idling();
        write_pool(24'd1000);
        run_mixed(125, 40, 1000);
        shuffle_idling();
        run_mixed(125, 40, 1000);

        // fragment the pool, overflow the table, then coalesce it back
        shuffle_idling();
        write_pool(24'd600);
        for (int n = 0; n < 140; n++)
            request_alloc(rand_units(1, 3));
        for (int i = (held_blocks.size() - 1) & ~1; i >= 0; i -= 2)
            release_held(i);
        shuffle_idling();
        for (int n = 0; n < 400 && held_blocks.size() != 0; n++)
            release_held($urandom_range(held_blocks.size() - 1, 0));

        // full-width pool and fields
        shuffle_idling();
        write_pool(UNIT_MAX);
        for (int n = 0; n < 150; n++) begin
            case ($urandom_range(9, 0))
                0, 1, 2: request_alloc(rand_units(0, 32'hFFFFFF) >> $urandom_range(23, 0));
                3: request_alloc(rand_units(0, 32'hFFFFFF));
                4, 5, 6: begin
                    if (held_blocks.size() != 0)
                        release_held($urandom_range(held_blocks.size() - 1, 0));
                    else
                        request_alloc(rand_units(1, 4096));
                end
                7: release_stray(UNIT_MAX - rand_units(0, 255), rand_units(0, 32'hFFFFFF));
                default: release_stray(rand_units(0, 32'hFFFFFF),
                                       rand_units(0, 32'hFFFFFF) >> $urandom_range(23, 0));
            endcase
        end

        // closing stretch at full rate
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_pool(rand_units(64, 4000));
        run_mixed(100, 64, 4000);

        wait_until_drained();
        repeat (400) @(posedge aclk);
        if (mismatch_count == 0)
            $display("first_fit_free_list_allocator_test OK");
        else
            $display("first_fit_free_list_allocator_test NOT OK");
        $finish;
    end

endmodule
